// ----- sv/srfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_pkg: shared types and constants of the sensor reply frame parser
// Frame markers, command codes, status codes and the result beat layout.
// ----------------------------------------------------------------------------
package srfp_pkg;

    // Field widths
    localparam int FUNC_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int PAYLOAD_W = 48;
    localparam int WORD_W    = 16;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    // Frame layout
    localparam logic [BYTE_W-1:0] HDR_BYTE       = 8'hAA;
    localparam logic [BYTE_W-1:0] TAIL_BYTE      = 8'hAB;
    localparam logic [BYTE_W-1:0] DATA_REPLY_CMD = 8'hC0;
    localparam logic [IDX_W-1:0]  FRAME_LEN      = 4'd10;
    localparam logic [IDX_W-1:0]  LAST_IDX       = FRAME_LEN - 4'd1;
    localparam logic [IDX_W-1:0]  IDX_HDR        = 4'd0;
    localparam logic [IDX_W-1:0]  IDX_CMD        = 4'd1;
    localparam logic [IDX_W-1:0]  IDX_DATA_FIRST = 4'd2;
    localparam logic [IDX_W-1:0]  IDX_DATA_LAST  = 4'd7;
    localparam logic [IDX_W-1:0]  IDX_SUM        = 4'd8;
    localparam logic [IDX_W-1:0]  IDX_TAIL       = 4'd9;
    localparam int                DATA_BYTES     = 6;

    // Function codes of an input beat
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

    // Status codes of a result beat
    localparam logic [STATUS_W-1:0] ST_PENDING = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FRAME   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_CMD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_DATA1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;
    localparam logic [CFG_W-1:0]     RST_EXP_CMD   = 8'hC0;
    localparam logic [CFG_W-1:0]     RST_EXP_DATA1 = 8'h00;
    localparam logic [CFG_W-1:0]     RST_TIMEOUT   = 8'hFF;

    localparam logic [BYTE_W-1:0] TICK_MAX = 8'hFF;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PAYLOAD_W-1:0] payload;
    } t_result;

endpackage

// ----- sv/srfp_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_in_if: input beat channel of the frame parser
// Valid/ready handshake carrying one function code and one received byte.
// ----------------------------------------------------------------------------
interface srfp_in_if;
    logic                          valid;
    logic                          ready;
    logic [srfp_pkg::FUNC_W-1:0]   func;
    logic [srfp_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

// ----- sv/srfp_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_out_if: result beat channel of the frame parser
// Valid/ready handshake carrying status, frame payload and the two words.
// ----------------------------------------------------------------------------
interface srfp_out_if;
    logic                             valid;
    logic                             ready;
    logic [srfp_pkg::STATUS_W-1:0]    status;
    logic [srfp_pkg::PAYLOAD_W-1:0]   payload;
    logic [srfp_pkg::WORD_W-1:0]      first_word;
    logic [srfp_pkg::WORD_W-1:0]      second_word;

    modport source (output valid, output status, output payload, output first_word,
                    output second_word, input ready);
    modport sink   (input valid, input status, input payload, input first_word,
                    input second_word, output ready);
endinterface

// ----- sv/sensor_reply_frame_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_reply_frame_parser_core: 10-byte sensor reply frame parser
// Checks header, command, first data byte (for non-data replies only),
// checksum and tail of a serial reply frame, counts millisecond ticks toward
// a timeout, and reports one result beat for every input beat.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  carries input beats: func START arms the parser, BYTE feeds one
//         received byte, TICK counts one millisecond while armed.
//   o_out carries exactly one result beat per input beat, in order:
//         PENDING, FRAME (payload and words valid), TIMEOUT or IGNORED.
//   Config: write i_cfg_data into register i_cfg_idx while i_cfg_we is high
//         (0 expected command, 1 expected first data byte, 2 timeout limit);
//         write only while no beat is in flight.
// Output: a result is registered in r_out, or in the skid register while o_out stalls.
// Throughput: one beat per cycle unless stalled; each beat is checked by one
//   pass of compare/add logic from the parser state into the result register.
// Reset: parser disarmed, all counters and registers but r_out and r_skd at
//   their reset values, no result pending.
// Stall: while o_out.ready is low one more beat is taken into a skid
//   register, then i_in.ready drops until the receiver takes a beat.
// ----------------------------------------------------------------------------
module sensor_reply_frame_parser_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    srfp_in_if.sink                           i_in,
    srfp_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [srfp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [srfp_pkg::CFG_W-1:0]        i_cfg_data
);

    // Configuration registers
    logic [srfp_pkg::CFG_W-1:0]     r_exp_cmd;
    logic [srfp_pkg::CFG_W-1:0]     r_exp_data1;
    logic [srfp_pkg::CFG_W-1:0]     r_timeout;

    // Parser state
    logic                           r_armed,    n_armed;
    logic [srfp_pkg::IDX_W-1:0]     r_byte_idx, n_byte_idx;
    logic [srfp_pkg::BYTE_W-1:0]    r_sum,      n_sum;
    logic [srfp_pkg::PAYLOAD_W-1:0] r_pay,      n_pay;
    logic [srfp_pkg::BYTE_W-1:0]    r_tick,     n_tick;

    // Output register and skid stage
    srfp_pkg::t_result              r_out,      n_out;
    srfp_pkg::t_result              r_skd;
    logic                           r_out_vld;
    logic                           r_skd_vld;

    srfp_pkg::t_result              res;
    logic                           in_fire;
    logic                           out_fire;
    logic                           byte_ok;
    logic [srfp_pkg::BYTE_W-1:0]    lim_m1;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_out_vld && o_out.ready;

    // A limit of zero acts as one: the first tick times out.
    assign lim_m1 = (r_timeout == '0) ? '0 : r_timeout - 8'd1;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_cmd   <= srfp_pkg::RST_EXP_CMD;
            r_exp_data1 <= srfp_pkg::RST_EXP_DATA1;
            r_timeout   <= srfp_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srfp_pkg::CFG_EXP_CMD:   r_exp_cmd   <= i_cfg_data;
                srfp_pkg::CFG_EXP_DATA1: r_exp_data1 <= i_cfg_data;
                srfp_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // One pass per beat: next state and result
    // ------------------------------------------------------------------
    always_comb begin
        n_armed    = r_armed;
        n_byte_idx = r_byte_idx;
        n_sum      = r_sum;
        n_pay      = r_pay;
        n_tick     = r_tick;
        byte_ok    = 1'b0;
        res        = '0;
        res.status = srfp_pkg::ST_PENDING;

        case (i_in.func)
            srfp_pkg::FUNC_START: begin
                // Re-arm even if a read is already running.
                n_armed    = 1'b1;
                n_byte_idx = '0;
                n_sum      = '0;
                n_pay      = '0;
                n_tick     = '0;
            end
            srfp_pkg::FUNC_BYTE: begin
                if (!r_armed) begin
                    res.status = srfp_pkg::ST_IGNORED;
                end else begin
                    case (r_byte_idx)
                        srfp_pkg::IDX_HDR:  byte_ok = (i_in.rx_byte == srfp_pkg::HDR_BYTE);
                        srfp_pkg::IDX_CMD:  byte_ok = (i_in.rx_byte == r_exp_cmd);
                        srfp_pkg::IDX_SUM:  byte_ok = (i_in.rx_byte == r_sum);
                        srfp_pkg::IDX_TAIL: byte_ok = (i_in.rx_byte == srfp_pkg::TAIL_BYTE);
                        default: begin
                            if (r_byte_idx >= srfp_pkg::IDX_DATA_FIRST &&
                                r_byte_idx <= srfp_pkg::IDX_DATA_LAST) begin
                                // First data byte is only checked for non-data replies.
                                byte_ok = (r_byte_idx != srfp_pkg::IDX_DATA_FIRST) ||
                                          (r_exp_cmd == srfp_pkg::DATA_REPLY_CMD) ||
                                          (i_in.rx_byte == r_exp_data1);
                                if (byte_ok) begin
                                    for (int k = 0; k < srfp_pkg::DATA_BYTES; k++) begin
                                        if (r_byte_idx == srfp_pkg::IDX_W'(k + 2)) begin
                                            n_pay[k*srfp_pkg::BYTE_W +: srfp_pkg::BYTE_W] =
                                                i_in.rx_byte;
                                        end
                                    end
                                    n_sum = (r_byte_idx == srfp_pkg::IDX_DATA_FIRST) ?
                                            i_in.rx_byte : r_sum + i_in.rx_byte;
                                end
                            end else begin
                                // Out-of-range position: drop and restart.
                                byte_ok = 1'b0;
                            end
                        end
                    endcase

                    if (!byte_ok) begin
                        n_byte_idx = '0;
                    end else if (r_byte_idx == srfp_pkg::LAST_IDX) begin
                        n_byte_idx  = '0;
                        n_armed     = 1'b0;
                        res.status  = srfp_pkg::ST_FRAME;
                        res.payload = r_pay;
                    end else begin
                        n_byte_idx = r_byte_idx + 4'd1;
                    end
                end
            end
            srfp_pkg::FUNC_TICK: begin
                if (r_armed) begin
                    n_tick = (r_tick == srfp_pkg::TICK_MAX) ? r_tick : r_tick + 8'd1;
                    if (n_tick >= lim_m1) begin
                        n_armed    = 1'b0;
                        res.status = srfp_pkg::ST_TIMEOUT;
                    end
                end
            end
            default: ;
        endcase
    end

    // Advance parser state on an accepted beat only.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_byte_idx <= '0;
            r_sum      <= '0;
            r_pay      <= '0;
            r_tick     <= '0;
        end else if (in_fire) begin
            r_armed    <= n_armed;
            r_byte_idx <= n_byte_idx;
            r_sum      <= n_sum;
            r_pay      <= n_pay;
            r_tick     <= n_tick;
        end
    end

    // ------------------------------------------------------------------
    // Output register plus skid stage
    // ------------------------------------------------------------------
    assign i_in.ready = !r_skd_vld;
    assign n_out      = r_skd_vld ? r_skd : res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            if (!r_out_vld || o_out.ready) begin
                // Output slot frees: refill from skid first, else from this beat.
                r_out_vld <= r_skd_vld || in_fire;
                r_skd_vld <= 1'b0;
            end else if (in_fire) begin
                // Receiver stalled: hold the new result in the skid stage.
                r_skd_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || o_out.ready) begin
            r_out <= n_out;
        end
        if (in_fire && r_out_vld && !o_out.ready) begin
            r_skd <= res;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.status      = r_out.status;
    assign o_out.payload     = r_out.payload;
    assign o_out.first_word  = r_out.payload[srfp_pkg::WORD_W-1:0];
    assign o_out.second_word = r_out.payload[2*srfp_pkg::WORD_W-1:srfp_pkg::WORD_W];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid stage full while output register empty");

    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_idx < srfp_pkg::FRAME_LEN)
        else $error("byte index beyond frame length");

    a_done_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (res.status == srfp_pkg::ST_FRAME || res.status == srfp_pkg::ST_TIMEOUT))
        |=> !r_armed)
        else $error("parser still armed after frame or timeout");

    a_payload_only_on_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status != srfp_pkg::ST_FRAME) |-> (r_out.payload == '0))
        else $error("payload nonzero on a non-frame result");

endmodule
